[sv/icfh_pkg.sv]
package icfh_pkg;

    // frame layout
    localparam logic [7:0] FRAME_MARK   = 8'h01;
    localparam int         FRAME_LEN    = 9;
    localparam logic [3:0] BODY_LEN     = 4'd8;   // bytes stored before the end marker
    localparam logic [3:0] LAST_POS     = 4'd8;   // position of the end marker
    localparam logic [7:0] MAX_VALUE    = 8'd2;

    // reply codes
    localparam logic [7:0] REPLY_OK     = 8'd0;
    localparam logic [7:0] REPLY_NO_CMD = 8'd2;

    // reply queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [7:0] {
        CMD_NONE     = 8'd0,
        CMD_SHOW     = 8'd1,
        CMD_CLEAR    = 8'd2,
        CMD_SET_MODE = 8'd3,
        CMD_STORE    = 8'd4,
        CMD_READ     = 8'd5
    } cmd_t;

    localparam logic [7:0] MAX_CMD = CMD_READ;

    // work handed from the front to the back
    typedef struct packed {
        logic        is_reply;    // 1: nine-byte reply, 0: display-only update
        logic [7:0]  code;
        logic [7:0]  value;
        logic [31:0] colour;      // red, green, blue, brightness from the top byte down
        logic [31:0] disp_colour;
        logic        disp_lit;
    } job_t;

endpackage

[sv/icfh_front.sv]
module icfh_front #(
    parameter int NUM_MODES = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_kind,
    input  logic [7:0]       in_byte,
    output logic             push,
    output icfh_pkg::job_t   push_job,
    input  logic             full
);

    localparam int IDX_W  = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int MODE_W = (IDX_W < 2) ? 2 : IDX_W;

    logic [7:0]        frame_reg [0:7];
    logic [3:0]        count_reg, count_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [31:0]       table_reg [0:NUM_MODES-1];
    logic [31:0]       shown_reg, shown_next;
    logic              lit_reg, lit_next;

    logic              accept;
    logic              frame_done;
    logic              good;
    logic [7:0]        sum8;
    icfh_pkg::cmd_t    cmd;
    logic [MODE_W:0]   inc_sum;
    logic [MODE_W:0]   inc_wrap;
    logic [MODE_W-1:0] mode_sel;
    logic              sel_in_range;
    logic [31:0]       rd_colour;
    logic [31:0]       frame_colour;
    logic              store_en;

    assign in_ready   = !full;
    assign accept     = in_valid && !full;
    assign frame_done = (count_reg == icfh_pkg::BODY_LEN);
    assign sum8       = frame_reg[1] + frame_reg[2] + frame_reg[3] +
                        frame_reg[4] + frame_reg[5] + frame_reg[6];
    assign cmd        = icfh_pkg::cmd_t'(frame_reg[1]);
    assign good       = (frame_reg[0] == icfh_pkg::FRAME_MARK) &&
                        (frame_reg[1] <= icfh_pkg::MAX_CMD) &&
                        (frame_reg[2] <= icfh_pkg::MAX_VALUE) &&
                        (frame_reg[7] == sum8) &&
                        (in_byte == icfh_pkg::FRAME_MARK);
    assign frame_colour = {frame_reg[3], frame_reg[4], frame_reg[5], frame_reg[6]};

    // mode advance with wrap; mode stays below twice the mode count
    assign inc_sum  = {1'b0, mode_reg} + (MODE_W+1)'(1);
    assign inc_wrap = (inc_sum >= (MODE_W+1)'(NUM_MODES)) ?
                      inc_sum - (MODE_W+1)'(NUM_MODES) : inc_sum;

    // mode in force after this transaction, and its colour slot
    always_comb begin
        mode_sel = mode_reg;
        if (in_kind) begin
            mode_sel = inc_wrap[MODE_W-1:0];
        end else if (frame_done && good && cmd == icfh_pkg::CMD_SET_MODE) begin
            mode_sel = frame_reg[2][MODE_W-1:0];
        end
    end

    assign sel_in_range = ({1'b0, mode_sel} < (MODE_W+1)'(NUM_MODES));
    assign rd_colour    = sel_in_range ? table_reg[mode_sel[IDX_W-1:0]] : table_reg[0];

    always_comb begin
        count_next = count_reg;
        mode_next  = mode_reg;
        shown_next = shown_reg;
        lit_next   = lit_reg;
        store_en   = 1'b0;
        push       = 1'b0;
        push_job   = '0;
        if (accept) begin
            if (in_kind) begin
                mode_next  = mode_sel;
                shown_next = rd_colour;
                lit_next   = 1'b1;
                push       = 1'b1;
            end else if (!frame_done) begin
                count_next = count_reg + 4'd1;
            end else begin
                count_next = '0;
                if (good) begin
                    push          = 1'b1;
                    push_job.is_reply = 1'b1;
                    push_job.code = icfh_pkg::REPLY_OK;
                    case (cmd)
                        icfh_pkg::CMD_SHOW: begin
                            shown_next = rd_colour;
                            lit_next   = 1'b1;
                        end
                        icfh_pkg::CMD_CLEAR: begin
                            shown_next = {24'd0, shown_reg[7:0]};
                            lit_next   = 1'b0;
                        end
                        icfh_pkg::CMD_SET_MODE: begin
                            mode_next  = mode_sel;
                            shown_next = rd_colour;
                            lit_next   = 1'b1;
                        end
                        icfh_pkg::CMD_STORE: begin
                            store_en = sel_in_range;
                        end
                        icfh_pkg::CMD_READ: begin
                            push_job.value  = 8'(mode_reg);
                            push_job.colour = rd_colour;
                        end
                        default: begin
                            push_job.code = icfh_pkg::REPLY_NO_CMD;
                        end
                    endcase
                end
            end
        end
        push_job.disp_colour = shown_next;
        push_job.disp_lit    = lit_next;
    end

    always_ff @(posedge aclk) begin
        if (accept && !in_kind && !frame_done) begin
            frame_reg[count_reg[2:0]] <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            mode_reg  <= '0;
            shown_reg <= '0;
            lit_reg   <= 1'b1;
            for (int i = 0; i < NUM_MODES; i++) begin
                table_reg[i] <= '0;
            end
        end else begin
            count_reg <= count_next;
            mode_reg  <= mode_next;
            shown_reg <= shown_next;
            lit_reg   <= lit_next;
            if (store_en) begin
                table_reg[mode_reg[IDX_W-1:0]] <= frame_colour;
            end
        end
    end

endmodule

[sv/icfh_queue.sv]
module icfh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  icfh_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output icfh_pkg::job_t head_job
);

    localparam int PTR_W = (icfh_pkg::QUEUE_DEPTH > 1) ? $clog2(icfh_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(icfh_pkg::QUEUE_DEPTH + 1);

    icfh_pkg::job_t   slot_reg [0:icfh_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(icfh_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_job = slot_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(icfh_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(icfh_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[sv/icfh_back.sv]
module icfh_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           empty,
    input  icfh_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_has_byte,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic [31:0]    out_colour,
    output logic           out_lit
);

    logic [3:0]  pos_reg, pos_next;
    logic        valid_reg, valid_next;
    logic        has_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] colour_reg;
    logic        lit_reg;

    logic        load;
    logic        job_end;
    logic [7:0]  cksum;
    logic [7:0]  cur_byte;

    assign load    = !empty && (!valid_reg || out_ready);
    assign job_end = !head_job.is_reply || (pos_reg == icfh_pkg::LAST_POS);
    assign pop     = load && job_end;
    assign cksum   = head_job.code + head_job.value +
                     head_job.colour[31:24] + head_job.colour[23:16] +
                     head_job.colour[15:8] + head_job.colour[7:0];

    always_comb begin
        case (pos_reg)
            4'd0:    cur_byte = icfh_pkg::FRAME_MARK;
            4'd1:    cur_byte = head_job.code;
            4'd2:    cur_byte = head_job.value;
            4'd3:    cur_byte = head_job.colour[31:24];
            4'd4:    cur_byte = head_job.colour[23:16];
            4'd5:    cur_byte = head_job.colour[15:8];
            4'd6:    cur_byte = head_job.colour[7:0];
            4'd7:    cur_byte = cksum;
            default: cur_byte = icfh_pkg::FRAME_MARK;
        endcase
    end

    always_comb begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            pos_next   = job_end ? 4'd0 : pos_reg + 4'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            has_reg    <= head_job.is_reply;
            byte_reg   <= head_job.is_reply ? cur_byte : 8'd0;
            last_reg   <= job_end;
            colour_reg <= head_job.disp_colour;
            lit_reg    <= head_job.disp_lit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_has_byte = has_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign out_colour   = colour_reg;
    assign out_lit      = lit_reg;

endmodule

[sv/indicator_command_frame_handler_core.sv]
// indicator command frame handler: received bytes (s_tuser 0) are gathered into fixed
// nine-byte frames with no resynchronization, and every ninth byte closes a frame. a good
// frame (start and end marker 0x01, command 0 to 5, value 0 to 2, additive checksum over
// bytes 1 to 6) runs its command and produces nine reply transactions with m_tuser 1,
// m_tlast on the last one; a bad frame or a byte inside a frame produces nothing. a button
// press (s_tuser 1) advances the mode and produces one display-only transaction with
// m_tuser 0 and m_tlast 1. every output transaction also carries the display state after
// its input was handled. the front end takes one transaction per cycle while the
// two-entry reply queue has room; the back end sends one output transaction per cycle
// while the queue holds work and m_tready allows, and the reply queue lets the input
// keep flowing while a result waits on m_tready, until the queue is full
module indicator_command_frame_handler_core #(
    parameter int NUM_MODES = 3
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] tx_byte, [15:8] led_red, [23:16] led_green,
                                   // [31:24] led_blue, [39:32] led_brightness,
                                   // [40] led_lit, [47:41] zero
    output logic        m_tuser,   // [0] has_byte
    output logic        m_tlast    // tx_last
);

    // front to queue
    logic           push;
    icfh_pkg::job_t push_job;
    logic           full;

    // queue to back
    logic           pop;
    logic           empty;
    icfh_pkg::job_t head_job;

    // back end result register
    logic [7:0]     tx_byte;
    logic [31:0]    led_colour;
    logic           led_lit;

    // frame gathering, checking and command execution
    icfh_front #(
        .NUM_MODES (NUM_MODES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_byte  (s_tdata),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    // decouples command execution from reply transmission
    icfh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_job (head_job)
    );

    // reply serializer with output register
    icfh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (empty),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_has_byte (m_tuser),
        .out_byte     (tx_byte),
        .out_last     (m_tlast),
        .out_colour   (led_colour),
        .out_lit      (led_lit)
    );

    // colour word holds red in the top byte down to brightness in the low byte
    assign m_tdata = {7'd0, led_lit, led_colour[7:0], led_colour[15:8],
                      led_colour[23:16], led_colour[31:24], tx_byte};

endmodule

[test/indicator_command_frame_handler_core_test.sv]
module indicator_command_frame_handler_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_MODES   = 3;
    localparam int STALL_LIMIT = 4000;  // cycles with no transaction on either side
    localparam int LONG_HOLD   = 200;   // receiver back-pressure stretch
    localparam int DRAIN_TAIL  = 20;    // quiet cycles after the last expected reply
    localparam int ITEM_GOAL   = 460;

    // what an input transaction carries in s_tuser
    localparam bit KIND_BYTE   = 1'b0;
    localparam bit KIND_BUTTON = 1'b1;

    // ways a frame can be spoiled on purpose
    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_CMD,
        FLAW_VALUE,
        FLAW_SUM,
        FLAW_END,
        FLAW_NOISE
    } frame_flaw_t;

    // one expected output transaction
    typedef struct {
        bit        has_byte;
        bit [7:0]  tx_byte;
        bit        tx_last;
        bit [31:0] colour;   // red, green, blue, brightness from the top byte down
        bit        lit;
    } tx_beat_t;

    // tracks the handler's state and the output transactions still owed
    class reply_tracker #(int MODES = 3);
        bit [7:0]  frame_buf [8];
        int        fill;
        bit [7:0]  mode;
        bit [31:0] slot_colour [MODES];
        bit [31:0] shown;
        bit        lit;
        tx_beat_t  awaited_tx [$];
        int        errors;

        function new();
            fill  = 0;
            mode  = 0;
            shown = 0;
            lit   = 1'b1;
            errors = 0;
            foreach (slot_colour[i]) slot_colour[i] = 0;
            foreach (frame_buf[i]) frame_buf[i] = 0;
        endfunction

        function int pending();
            return awaited_tx.size();
        endfunction

        function bit [31:0] mode_colour();
            // a mode without a slot falls back to slot 0
            return (mode < MODES) ? slot_colour[mode] : slot_colour[0];
        endfunction

        function void show_mode();
            shown = mode_colour();
            lit   = 1'b1;
        endfunction

        function void push_beat(bit has, bit [7:0] b, bit last);
            tx_beat_t t;
            t.has_byte = has;
            t.tx_byte  = b;
            t.tx_last  = last;
            t.colour   = shown;
            t.lit      = lit;
            awaited_tx.push_back(t);
        endfunction

        function void queue_reply(bit [7:0] code, bit [7:0] value, bit [31:0] colour);
            bit [7:0] f [9];
            f[0] = icfh_pkg::FRAME_MARK;
            f[1] = code;
            f[2] = value;
            f[3] = colour[31:24];
            f[4] = colour[23:16];
            f[5] = colour[15:8];
            f[6] = colour[7:0];
            f[7] = f[1] + f[2] + f[3] + f[4] + f[5] + f[6];
            f[8] = icfh_pkg::FRAME_MARK;
            for (int i = 0; i < icfh_pkg::FRAME_LEN; i++)
                push_beat(1'b1, f[i], i == icfh_pkg::FRAME_LEN - 1);
        endfunction

        // accepted input transaction: advance the state, queue what it causes
        function void log_input(bit kind, bit [7:0] rx);
            bit [7:0]  sum;
            bit [31:0] colour;
            if (kind == KIND_BUTTON) begin
                mode = 8'((int'(mode) + 1) % MODES);
                show_mode();
                push_beat(1'b0, 8'h00, 1'b1);
                return;
            end
            if (fill < icfh_pkg::BODY_LEN) begin
                frame_buf[fill] = rx;
                fill++;
                return;
            end
            fill = 0;
            sum = frame_buf[1] + frame_buf[2] + frame_buf[3] + frame_buf[4]
                + frame_buf[5] + frame_buf[6];
            if (frame_buf[0] != icfh_pkg::FRAME_MARK || frame_buf[1] > icfh_pkg::MAX_CMD ||
                frame_buf[2] > icfh_pkg::MAX_VALUE || frame_buf[7] != sum ||
                rx != icfh_pkg::FRAME_MARK)
                return;
            colour = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
            case (icfh_pkg::cmd_t'(frame_buf[1]))
                icfh_pkg::CMD_SHOW: begin
                    show_mode();
                    queue_reply(icfh_pkg::REPLY_OK, 8'h00, 32'h0);
                end
                icfh_pkg::CMD_CLEAR: begin
                    shown &= 32'h0000_00ff;
                    lit = 1'b0;
                    queue_reply(icfh_pkg::REPLY_OK, 8'h00, 32'h0);
                end
                icfh_pkg::CMD_SET_MODE: begin
                    mode = frame_buf[2];
                    show_mode();
                    queue_reply(icfh_pkg::REPLY_OK, 8'h00, 32'h0);
                end
                icfh_pkg::CMD_STORE: begin
                    if (mode < MODES) slot_colour[mode] = colour;
                    queue_reply(icfh_pkg::REPLY_OK, 8'h00, 32'h0);
                end
                icfh_pkg::CMD_READ: queue_reply(icfh_pkg::REPLY_OK, mode, mode_colour());
                default: queue_reply(icfh_pkg::REPLY_NO_CMD, 8'h00, 32'h0);
            endcase
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // accepted output transaction against the oldest expectation
        function void check_tx(bit has, bit last, bit [47:0] data);
            tx_beat_t e;
            if (awaited_tx.size() == 0) begin
                $error("unexpected output transaction: tdata 0x%0h", data);
                errors++;
                return;
            end
            e = awaited_tx.pop_front();
            check_field("has_byte", e.has_byte, has);
            check_field("tx_byte", e.tx_byte, data[7:0]);
            check_field("tx_last", e.tx_last, last);
            check_field("led_red", e.colour[31:24], data[15:8]);
            check_field("led_green", e.colour[23:16], data[23:16]);
            check_field("led_blue", e.colour[15:8], data[31:24]);
            check_field("led_brightness", e.colour[7:0], data[39:32]);
            check_field("led_lit", e.lit, data[40]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    reply_tracker #(NUM_MODES) tracker;

    bit idling;          // random gaps on both sides when set
    bit hold_output;     // asks the receiver for one long back-pressure stretch
    int items_sent;
    int stuck_cycles;

    indicator_command_frame_handler_core #(
        .NUM_MODES(NUM_MODES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // offer one input transaction, starting from the posedge of the previous one;
    // returns at the posedge where it was accepted, tvalid still high
    task automatic send_item(input bit kind, input bit [7:0] rx);
        int gap;
        gap = idling ? $urandom_range(0, 8) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = rx;
        do @(posedge aclk); while (!s_tready);
        tracker.log_input(kind, rx);
        items_sent++;
    endtask

    // drop tvalid and wait until every owed output transaction has gone out
    task automatic drain_outputs();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
    endtask

    function automatic bit [7:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // nine serial bytes, optionally spoiled, with random button presses mixed in
    task automatic send_frame(input bit [7:0] cmd, input bit [7:0] val,
                              input bit [31:0] colour, input frame_flaw_t flaw,
                              input int press_pct);
        bit [7:0] f [9];
        f[1] = (flaw == FLAW_CMD) ?
               8'($urandom_range(icfh_pkg::MAX_CMD + 1, 255)) : cmd;
        f[2] = (flaw == FLAW_VALUE) ?
               8'($urandom_range(icfh_pkg::MAX_VALUE + 1, 255)) : val;
        f[0] = icfh_pkg::FRAME_MARK;
        f[3] = colour[31:24];
        f[4] = colour[23:16];
        f[5] = colour[15:8];
        f[6] = colour[7:0];
        f[7] = f[1] + f[2] + f[3] + f[4] + f[5] + f[6];
        f[8] = icfh_pkg::FRAME_MARK;
        case (flaw)
            FLAW_START: do f[0] = 8'($urandom_range(0, 255));
                        while (f[0] == icfh_pkg::FRAME_MARK);
            FLAW_SUM:   f[7] ^= 8'($urandom_range(1, 255));
            FLAW_END:   do f[8] = 8'($urandom_range(0, 255));
                        while (f[8] == icfh_pkg::FRAME_MARK);
            FLAW_NOISE: foreach (f[i]) f[i] = 8'($urandom_range(0, 255));
            default: ;
        endcase
        for (int i = 0; i < icfh_pkg::FRAME_LEN; i++) begin
            // a press in the middle of a frame must leave the gathered bytes alone
            if ($urandom_range(0, 99) < press_pct)
                send_item(KIND_BUTTON, 8'($urandom_range(0, 255)));
            send_item(KIND_BYTE, f[i]);
        end
    endtask

    // receiver: random stalls per transaction, one long hold on request
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_output) begin
                stall = LONG_HOLD;
                hold_output = 1'b0;
            end else begin
                stall = idling ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // output monitor, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_tx(m_tuser, m_tlast, m_tdata);
    end

    // watchdog: too long without any transaction means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("indicator_command_frame_handler_core: mismatch");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        frame_flaw_t flaw;
        tracker      = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = KIND_BYTE;
        idling       = 1'b0;
        hold_output  = 1'b0;
        items_sent   = 0;
        stuck_cycles = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // directed: a press, then store full-scale colour for the new mode and read it back,
        // then an unknown-command frame answered with the no-command code
        send_item(KIND_BUTTON, 8'h00);
        send_frame(icfh_pkg::CMD_STORE, icfh_pkg::MAX_VALUE, 32'hffff_ffff, FLAW_NONE, 0);
        send_frame(icfh_pkg::CMD_READ, 8'h00, 32'h0000_0000, FLAW_NONE, 0);
        send_frame(icfh_pkg::CMD_NONE, 8'h00, 32'hffff_ffff, FLAW_NONE, 0);

        // random: mostly good frames with random content, some spoiled ones and noise
        for (int k = 0; items_sent < ITEM_GOAL; k++) begin
            if (k % 4 == 0) idling = ($urandom_range(0, 3) != 0);
            if (k == 8) hold_output = 1'b1;
            if (k == 20) drain_outputs();
            if ($urandom_range(0, 99) < 75)
                flaw = FLAW_NONE;
            else
                flaw = frame_flaw_t'($urandom_range(FLAW_START, FLAW_NOISE));
            send_frame(8'($urandom_range(icfh_pkg::CMD_NONE, icfh_pkg::CMD_READ)),
                       8'($urandom_range(0, icfh_pkg::MAX_VALUE)),
                       {pick_level(), pick_level(), pick_level(), pick_level()},
                       flaw, 6);
        end

        drain_outputs();
        // anything arriving now is unexpected and gets flagged by the monitor
        repeat (DRAIN_TAIL) @(negedge aclk);
        if (tracker.errors == 0)
            $display("indicator_command_frame_handler_core: match");
        else
            $display("indicator_command_frame_handler_core: mismatch");
        $finish;
    end

endmodule

[filelist.f]
sv/icfh_pkg.sv
sv/icfh_front.sv
sv/icfh_queue.sv
sv/icfh_back.sv
sv/indicator_command_frame_handler_core.sv
test/indicator_command_frame_handler_core_test.sv
